### design/two_level_queue_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// Two-level queue scheduler assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_QUEUE_SCHEDULER_UNIT_MACROS_SVH
`define TWO_LEVEL_QUEUE_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define TLQS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TLQS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/tlqs_pkg.sv
// ----------------------------------------------------------------------------
// Two-level queue scheduler package
// Codes, sequencer states and user list operations.
// ----------------------------------------------------------------------------
`default_nettype none

package tlqs_pkg;

   localparam logic ACTION_ARRIVE = 1'b0;
   localparam logic ACTION_TICK   = 1'b1;

   localparam logic [1:0] STATUS_ACCEPT = 2'd0;
   localparam logic [1:0] STATUS_DROP   = 2'd1;
   localparam logic [1:0] STATUS_RUN    = 2'd2;
   localparam logic [1:0] STATUS_IDLE   = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREEMPT,
      S_SELECT,
      S_SCAN,
      S_TAKE,
      S_RUN,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      UOP_NONE,
      UOP_APPEND,
      UOP_REMOVE
   } user_op_type;

endpackage

`default_nettype wire

### design/tlqs_req_if.sv
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel carrying arrive and tick items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlqs_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  proc_id;
   logic [15:0] burst;
   logic        is_system;

   modport source (output valid, action, proc_id, burst, is_system, input ready);
   modport sink   (input valid, action, proc_id, burst, is_system, output ready);
endinterface

`default_nettype wire

### design/tlqs_rsp_if.sv
// ----------------------------------------------------------------------------
// Scheduler response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlqs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  run_id;
   logic        done_res;
   logic [31:0] finish_time;
   logic [31:0] turnaround;
   logic [31:0] waiting;

   modport source (output valid, status, run_id, done_res, finish_time, turnaround,
                   waiting, input ready);
   modport sink   (input valid, status, run_id, done_res, finish_time, turnaround,
                   waiting, output ready);
endinterface

`default_nettype wire

### design/tlqs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlqs_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### design/tlqs_user_cell.sv
// ----------------------------------------------------------------------------
// User list cell
// Holds one user entry, shifts from its right neighbor on removal and
// passes the running shortest-remaining candidate to its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module tlqs_user_cell #(
   parameter int IDX_BITS  = 4,
   parameter int CNT_BITS  = 5,
   parameter int TIME_BITS = 32,
   parameter int INDEX     = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tlqs_pkg::user_op_type op,
   input  wire logic [IDX_BITS-1:0]   sel_idx,
   input  wire logic [CNT_BITS-1:0]   count,
   input  wire logic [7:0]            wr_id,
   input  wire logic [TIME_BITS-1:0]  wr_arrival,
   input  wire logic [15:0]           wr_burst,
   input  wire logic [15:0]           wr_rem,
   input  wire logic [7:0]            nxt_id,
   input  wire logic [TIME_BITS-1:0]  nxt_arrival,
   input  wire logic [15:0]           nxt_burst,
   input  wire logic [15:0]           nxt_rem,
   output logic      [7:0]            ent_id,
   output logic      [TIME_BITS-1:0]  ent_arrival,
   output logic      [15:0]           ent_burst,
   output logic      [15:0]           ent_rem,
   input  wire logic                  cin_found,
   input  wire logic [IDX_BITS-1:0]   cin_idx,
   input  wire logic [7:0]            cin_id,
   input  wire logic [TIME_BITS-1:0]  cin_arrival,
   input  wire logic [15:0]           cin_burst,
   input  wire logic [15:0]           cin_rem,
   output logic                       cout_found,
   output logic      [IDX_BITS-1:0]   cout_idx,
   output logic      [7:0]            cout_id,
   output logic      [TIME_BITS-1:0]  cout_arrival,
   output logic      [15:0]           cout_burst,
   output logic      [15:0]           cout_rem
);

   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);
   localparam logic [CNT_BITS-1:0] MY_CNT = CNT_BITS'(INDEX);

   logic occupied;
   logic take;

   assign occupied = MY_CNT < count;
   assign take     = occupied && (!cin_found || (ent_rem < cin_rem));

   always_ff @(posedge clock) begin
      if (op == tlqs_pkg::UOP_APPEND && sel_idx == MY_IDX) begin
         ent_id      <= wr_id;
         ent_arrival <= wr_arrival;
         ent_burst   <= wr_burst;
         ent_rem     <= wr_rem;
      end else if (op == tlqs_pkg::UOP_REMOVE && MY_IDX >= sel_idx) begin
         ent_id      <= nxt_id;
         ent_arrival <= nxt_arrival;
         ent_burst   <= nxt_burst;
         ent_rem     <= nxt_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cout_found <= 1'b0;
      end else begin
         cout_found <= cin_found || occupied;
      end
      if (take) begin
         cout_idx     <= MY_IDX;
         cout_id      <= ent_id;
         cout_arrival <= ent_arrival;
         cout_burst   <= ent_burst;
         cout_rem     <= ent_rem;
      end else begin
         cout_idx     <= cin_idx;
         cout_id      <= cin_id;
         cout_arrival <= cin_arrival;
         cout_burst   <= cin_burst;
         cout_rem     <= cin_rem;
      end
   end

endmodule

`default_nettype wire

### design/two_level_queue_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Two-level queue scheduler
// System class FIFO with preemption over a user list picked by shortest
// remaining time.
// ----------------------------------------------------------------------------
// Usage: req_ch carries arrive items (action 0) and tick items (action 1);
// rsp_ch returns exactly one result per request, in order.
// Requests are taken one at a time. An arrive goes from idle straight to
// the output state. A tick passes through preempt, select and, if a job
// runs, run before output; one that picks from the user list first walks
// the scan and take states, the scan as long as the cell chain that the
// shortest-remaining search walks through.
// The result sits in an output register, so a new request is taken while
// the previous result waits; a stalled rsp_ch holds the following result in
// the sequencer until the register frees up.
// Reset (synchronous) empties both queues, drops the running job and
// clears the time counter; queue storage itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_queue_scheduler_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tlqs_req_if.sink   req_ch,
   tlqs_rsp_if.source rsp_ch
);

   localparam int IDX_BITS  = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int SCAN_BITS = $clog2(QUEUE_DEPTH + 2);
   localparam int RAM_WIDTH = 8 + TIME_BITS + 16;
   localparam int EXT_BITS  = TIME_BITS + 32;
   localparam logic [CNT_BITS-1:0]  FULL_CNT  = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [IDX_BITS-1:0]  LAST_IDX  = IDX_BITS'(QUEUE_DEPTH - 1);
   localparam logic [SCAN_BITS-1:0] SCAN_LAST = SCAN_BITS'(QUEUE_DEPTH);

   tlqs_pkg::state_type state_ff, state_in;

   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [IDX_BITS-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CNT_BITS-1:0]  sys_cnt_ff, sys_cnt_in, usr_cnt_ff, usr_cnt_in;
   logic [SCAN_BITS-1:0] scan_ff, scan_in;

   logic                 cur_valid_ff, cur_valid_in, cur_sys_ff, cur_sys_in;
   logic [7:0]           cur_id_ff, cur_id_in;
   logic [TIME_BITS-1:0] cur_arr_ff, cur_arr_in;
   logic [15:0]          cur_burst_ff, cur_burst_in, cur_rem_ff, cur_rem_in;

   logic [1:0]  pend_status_ff, pend_status_in;
   logic [7:0]  pend_id_ff, pend_id_in;
   logic        pend_done_ff, pend_done_in;
   logic [31:0] pend_fin_ff, pend_fin_in, pend_tat_ff, pend_tat_in;
   logic [31:0] pend_wait_ff, pend_wait_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_id_ff, rsp_id_in;
   logic        rsp_done_ff, rsp_done_in;
   logic [31:0] rsp_fin_ff, rsp_fin_in, rsp_tat_ff, rsp_tat_in, rsp_wait_ff, rsp_wait_in;

   logic                 ram_we;
   logic [RAM_WIDTH-1:0] ram_wdata, ram_rdata;

   tlqs_pkg::user_op_type uop;
   logic [IDX_BITS-1:0]   usel;
   logic [7:0]            uwr_id;
   logic [TIME_BITS-1:0]  uwr_arr;
   logic [15:0]           uwr_burst, uwr_rem;

   logic [7:0]           ent_id  [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] ent_arr [QUEUE_DEPTH];
   logic [15:0]          ent_bst [QUEUE_DEPTH];
   logic [15:0]          ent_rem [QUEUE_DEPTH];
   logic                 c_found [QUEUE_DEPTH];
   logic [IDX_BITS-1:0]  c_idx   [QUEUE_DEPTH];
   logic [7:0]           c_id    [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] c_arr   [QUEUE_DEPTH];
   logic [15:0]          c_bst   [QUEUE_DEPTH];
   logic [15:0]          c_rem   [QUEUE_DEPTH];

   logic [15:0]          rem_dec;
   logic [TIME_BITS-1:0] time_inc, tat_full, wait_full;
   logic [EXT_BITS-1:0]  fin_ext, tat_ext, wait_ext;

   tlqs_ram #(.WIDTH(RAM_WIDTH), .DEPTH(QUEUE_DEPTH)) u_sys_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (ram_wdata),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   assign ram_wdata = {req_ch.proc_id, time_ff, req_ch.burst};

   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      localparam int NK = (k == QUEUE_DEPTH - 1) ? k : k + 1;
      localparam int PK = (k == 0) ? 0 : k - 1;

      tlqs_user_cell #(
         .IDX_BITS  (IDX_BITS),
         .CNT_BITS  (CNT_BITS),
         .TIME_BITS (TIME_BITS),
         .INDEX     (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .op           (uop),
         .sel_idx      (usel),
         .count        (usr_cnt_ff),
         .wr_id        (uwr_id),
         .wr_arrival   (uwr_arr),
         .wr_burst     (uwr_burst),
         .wr_rem       (uwr_rem),
         .nxt_id       (ent_id[NK]),
         .nxt_arrival  (ent_arr[NK]),
         .nxt_burst    (ent_bst[NK]),
         .nxt_rem      (ent_rem[NK]),
         .ent_id       (ent_id[k]),
         .ent_arrival  (ent_arr[k]),
         .ent_burst    (ent_bst[k]),
         .ent_rem      (ent_rem[k]),
         .cin_found    ((k == 0) ? 1'b0 : c_found[PK]),
         .cin_idx      (c_idx[PK]),
         .cin_id       (c_id[PK]),
         .cin_arrival  (c_arr[PK]),
         .cin_burst    (c_bst[PK]),
         .cin_rem      (c_rem[PK]),
         .cout_found   (c_found[k]),
         .cout_idx     (c_idx[k]),
         .cout_id      (c_id[k]),
         .cout_arrival (c_arr[k]),
         .cout_burst   (c_bst[k]),
         .cout_rem     (c_rem[k])
      );
   end

   assign rem_dec   = cur_rem_ff - 16'd1;
   assign time_inc  = time_ff + 1'b1;
   assign tat_full  = time_inc - cur_arr_ff;
   assign wait_full = tat_full - TIME_BITS'(cur_burst_ff);
   assign fin_ext   = {32'd0, time_inc};
   assign tat_ext   = {32'd0, tat_full};
   assign wait_ext  = {32'd0, wait_full};

   assign req_ch.ready       = (state_ff == tlqs_pkg::S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.run_id      = rsp_id_ff;
   assign rsp_ch.done_res    = rsp_done_ff;
   assign rsp_ch.finish_time = rsp_fin_ff;
   assign rsp_ch.turnaround  = rsp_tat_ff;
   assign rsp_ch.waiting     = rsp_wait_ff;

   always_comb begin
      state_in       = state_ff;
      time_in        = time_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      sys_cnt_in     = sys_cnt_ff;
      usr_cnt_in     = usr_cnt_ff;
      scan_in        = scan_ff;
      cur_valid_in   = cur_valid_ff;
      cur_sys_in     = cur_sys_ff;
      cur_id_in      = cur_id_ff;
      cur_arr_in     = cur_arr_ff;
      cur_burst_in   = cur_burst_ff;
      cur_rem_in     = cur_rem_ff;
      pend_status_in = pend_status_ff;
      pend_id_in     = pend_id_ff;
      pend_done_in   = pend_done_ff;
      pend_fin_in    = pend_fin_ff;
      pend_tat_in    = pend_tat_ff;
      pend_wait_in   = pend_wait_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_fin_in     = rsp_fin_ff;
      rsp_tat_in     = rsp_tat_ff;
      rsp_wait_in    = rsp_wait_ff;
      ram_we         = 1'b0;
      uop            = tlqs_pkg::UOP_NONE;
      usel           = usr_cnt_ff[IDX_BITS-1:0];
      uwr_id         = req_ch.proc_id;
      uwr_arr        = time_ff;
      uwr_burst      = req_ch.burst;
      uwr_rem        = req_ch.burst;

      case (state_ff)
         tlqs_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               pend_id_in   = 8'd0;
               pend_done_in = 1'b0;
               pend_fin_in  = 32'd0;
               pend_tat_in  = 32'd0;
               pend_wait_in = 32'd0;
               if (req_ch.action == tlqs_pkg::ACTION_TICK) begin
                  state_in = tlqs_pkg::S_PREEMPT;
               end else begin
                  state_in       = tlqs_pkg::S_OUT;
                  pend_status_in = tlqs_pkg::STATUS_DROP;
                  if (req_ch.burst != 16'd0) begin
                     if (req_ch.is_system) begin
                        if (sys_cnt_ff != FULL_CNT) begin
                           ram_we         = 1'b1;
                           tail_in        = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
                           sys_cnt_in     = sys_cnt_ff + 1'b1;
                           pend_status_in = tlqs_pkg::STATUS_ACCEPT;
                        end
                     end else if (usr_cnt_ff != FULL_CNT) begin
                        uop            = tlqs_pkg::UOP_APPEND;
                        usr_cnt_in     = usr_cnt_ff + 1'b1;
                        pend_status_in = tlqs_pkg::STATUS_ACCEPT;
                     end
                  end
               end
            end
         end
         tlqs_pkg::S_PREEMPT: begin
            state_in = tlqs_pkg::S_SELECT;
            if (cur_valid_ff && !cur_sys_ff && sys_cnt_ff != '0 && usr_cnt_ff != FULL_CNT) begin
               uop          = tlqs_pkg::UOP_APPEND;
               uwr_id       = cur_id_ff;
               uwr_arr      = cur_arr_ff;
               uwr_burst    = cur_burst_ff;
               uwr_rem      = cur_rem_ff;
               usr_cnt_in   = usr_cnt_ff + 1'b1;
               cur_valid_in = 1'b0;
            end
         end
         tlqs_pkg::S_SELECT: begin
            if (cur_valid_ff) begin
               state_in = tlqs_pkg::S_RUN;
            end else if (sys_cnt_ff != '0) begin
               state_in     = tlqs_pkg::S_RUN;
               cur_valid_in = 1'b1;
               cur_sys_in   = 1'b1;
               cur_id_in    = ram_rdata[RAM_WIDTH-1 -: 8];
               cur_arr_in   = ram_rdata[TIME_BITS+15:16];
               cur_burst_in = ram_rdata[15:0];
               cur_rem_in   = ram_rdata[15:0];
               head_in      = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
               sys_cnt_in   = sys_cnt_ff - 1'b1;
            end else if (usr_cnt_ff != '0) begin
               state_in = tlqs_pkg::S_SCAN;
               scan_in  = '0;
            end else begin
               state_in       = tlqs_pkg::S_OUT;
               time_in        = time_inc;
               pend_status_in = tlqs_pkg::STATUS_IDLE;
            end
         end
         tlqs_pkg::S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == SCAN_LAST) begin
               state_in = tlqs_pkg::S_TAKE;
            end
         end
         tlqs_pkg::S_TAKE: begin
            state_in     = tlqs_pkg::S_RUN;
            uop          = tlqs_pkg::UOP_REMOVE;
            usel         = c_idx[QUEUE_DEPTH-1];
            usr_cnt_in   = usr_cnt_ff - 1'b1;
            cur_valid_in = 1'b1;
            cur_sys_in   = 1'b0;
            cur_id_in    = c_id[QUEUE_DEPTH-1];
            cur_arr_in   = c_arr[QUEUE_DEPTH-1];
            cur_burst_in = c_bst[QUEUE_DEPTH-1];
            cur_rem_in   = c_rem[QUEUE_DEPTH-1];
         end
         tlqs_pkg::S_RUN: begin
            state_in       = tlqs_pkg::S_OUT;
            time_in        = time_inc;
            cur_rem_in     = rem_dec;
            pend_status_in = tlqs_pkg::STATUS_RUN;
            pend_id_in     = cur_id_ff;
            if (rem_dec == 16'd0) begin
               cur_valid_in = 1'b0;
               pend_done_in = 1'b1;
               pend_fin_in  = fin_ext[31:0];
               pend_tat_in  = tat_ext[31:0];
               pend_wait_in = wait_ext[31:0];
            end
         end
         tlqs_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in      = tlqs_pkg::S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_id_in     = pend_id_ff;
               rsp_done_in   = pend_done_ff;
               rsp_fin_in    = pend_fin_ff;
               rsp_tat_in    = pend_tat_ff;
               rsp_wait_in   = pend_wait_ff;
            end
         end
         default: begin
            state_in = tlqs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlqs_pkg::S_IDLE;
         time_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         sys_cnt_ff   <= '0;
         usr_cnt_ff   <= '0;
         cur_valid_ff <= 1'b0;
         cur_sys_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         sys_cnt_ff   <= sys_cnt_in;
         usr_cnt_ff   <= usr_cnt_in;
         cur_valid_ff <= cur_valid_in;
         cur_sys_ff   <= cur_sys_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff        <= scan_in;
      cur_id_ff      <= cur_id_in;
      cur_arr_ff     <= cur_arr_in;
      cur_burst_ff   <= cur_burst_in;
      cur_rem_ff     <= cur_rem_in;
      pend_status_ff <= pend_status_in;
      pend_id_ff     <= pend_id_in;
      pend_done_ff   <= pend_done_in;
      pend_fin_ff    <= pend_fin_in;
      pend_tat_ff    <= pend_tat_in;
      pend_wait_ff   <= pend_wait_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_fin_ff     <= rsp_fin_in;
      rsp_tat_ff     <= rsp_tat_in;
      rsp_wait_ff    <= rsp_wait_in;
   end

endmodule

`default_nettype wire

### design/tlqs_checker.sv
// ----------------------------------------------------------------------------
// Two-level queue scheduler checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_level_queue_scheduler_unit_macros.svh"

module tlqs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [7:0]  rsp_run_id,
   input wire logic        rsp_done_res,
   input wire logic [31:0] rsp_finish_time,
   input wire logic [31:0] rsp_turnaround,
   input wire logic [31:0] rsp_waiting
);

   `TLQS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
   `TLQS_ASSERT_NOW(a_done_on_run, clock, reset, rsp_valid && rsp_done_res, rsp_status == tlqs_pkg::STATUS_RUN, "done without run")
   `TLQS_ASSERT_NOW(a_id_zero, clock, reset, rsp_valid && rsp_status != tlqs_pkg::STATUS_RUN, rsp_run_id == 8'd0 && !rsp_done_res, "run_id set without run")
   `TLQS_ASSERT_NOW(a_times_zero, clock, reset, rsp_valid && !rsp_done_res, rsp_finish_time == 32'd0 && rsp_turnaround == 32'd0 && rsp_waiting == 32'd0, "times set without finish")

endmodule

bind two_level_queue_scheduler_unit tlqs_checker u_tlqs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_run_id      (rsp_ch.run_id),
   .rsp_done_res    (rsp_ch.done_res),
   .rsp_finish_time (rsp_ch.finish_time),
   .rsp_turnaround  (rsp_ch.turnaround),
   .rsp_waiting     (rsp_ch.waiting)
);

`default_nettype wire
